### src/gec_pkg.sv
// Shared types, constants and helper functions for the greedy edge coloring block.
// No dependencies; the other files that use it refer to this package by scoped names.

package gec_pkg;

    // Store and field sizing.
    localparam int MAX_EDGES   = 1024;
    localparam int VERTEX_BITS = 16;
    localparam int MAX_COLORS  = 64;

    localparam int EDGE_AW  = $clog2(MAX_EDGES);
    localparam int HELD_W   = $clog2(MAX_EDGES + 1);
    localparam int COLOR_W  = $clog2(MAX_COLORS);
    localparam int USED_W   = $clog2(MAX_COLORS + 1);
    localparam int PORT_VW  = 16;
    localparam int STATUS_W = 2;

    // Status codes reported with every result word.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_COLOR_LIMIT = 2'd1,
        STATUS_STORE_FULL  = 2'd2
    } status_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK
    } fsm_state_t;

    // One entry of the edge store.
    typedef struct packed {
        logic [VERTEX_BITS-1:0] first_end;
        logic [VERTEX_BITS-1:0] second_end;
        logic [COLOR_W-1:0]     color;
    } edge_entry_t;

    localparam int ENTRY_W = $bits(edge_entry_t);

    // Outcome of the free color search.
    typedef struct packed {
        logic               found;
        logic [COLOR_W-1:0] color;
    } pick_t;

    // Lowest color whose taken bit is clear; saturates when all are taken.
    function automatic pick_t first_free(input logic [MAX_COLORS-1:0] taken);
        pick_t res;
        res.found = 1'b0;
        res.color = COLOR_W'(MAX_COLORS - 1);
        for (int i = MAX_COLORS - 1; i >= 0; i--)
        begin
            if (!taken[i])
            begin
                res.found = 1'b1;
                res.color = COLOR_W'(i);
            end
        end
        return res;
    endfunction

endpackage

### src/gec_channels.sv
// Valid/ready channel interfaces for edge words and result words.
// Depends on gec_pkg for field widths.

interface gec_edge_if;
    logic                         valid;
    logic                         ready;
    logic [gec_pkg::PORT_VW-1:0]  vertex_a;
    logic [gec_pkg::PORT_VW-1:0]  vertex_b;
    logic                         last_edge;

    modport source (output valid, vertex_a, vertex_b, last_edge, input ready);
    modport sink   (input valid, vertex_a, vertex_b, last_edge, output ready);
endinterface

interface gec_result_if;
    logic                           valid;
    logic                           ready;
    logic [gec_pkg::COLOR_W-1:0]    edge_color;
    logic [gec_pkg::EDGE_AW-1:0]    edge_number;
    logic [gec_pkg::USED_W-1:0]     colors_used;
    logic [gec_pkg::STATUS_W-1:0]   status;
    logic                           graph_done;

    modport source (output valid, edge_color, edge_number, colors_used, status, graph_done,
                    input ready);
    modport sink   (input valid, edge_color, edge_number, colors_used, status, graph_done,
                    output ready);
endinterface

### src/gec_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.

module gec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/gec_scan.sv
// Scan engine: reads every stored edge of the current graph from the edge store
// and collects the colors held by edges that share an endpoint. Depends on gec_pkg.

module gec_scan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [gec_pkg::HELD_W-1:0]        held,
    input  logic [gec_pkg::VERTEX_BITS-1:0]   vertex_a,
    input  logic [gec_pkg::VERTEX_BITS-1:0]   vertex_b,
    output logic                              rd_en,
    output logic [gec_pkg::EDGE_AW-1:0]       rd_addr,
    input  gec_pkg::edge_entry_t              rd_data,
    output logic [gec_pkg::MAX_COLORS-1:0]    taken,
    output logic                              done
);

    logic                             busy_reg, busy_next;
    logic                             pend_reg, pend_next;
    logic                             done_reg, done_next;
    logic [gec_pkg::HELD_W-1:0]       addr_reg, addr_next;
    logic [gec_pkg::MAX_COLORS-1:0]   taken_reg, taken_next;
    logic                             adjacent;

    // A returned entry is adjacent when any of its ends meets either new end.
    assign adjacent = (rd_data.first_end  == vertex_a) || (rd_data.second_end == vertex_a) ||
                      (rd_data.first_end  == vertex_b) || (rd_data.second_end == vertex_b);

    assign rd_en   = busy_reg && (addr_reg < held);
    assign rd_addr = addr_reg[gec_pkg::EDGE_AW-1:0];
    assign taken   = taken_reg;
    assign done    = done_reg;

    // Issue one read a cycle and fold the previous cycle's data into the mask.
    always_comb
    begin
        busy_next  = busy_reg;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        addr_next  = addr_reg;
        taken_next = taken_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            addr_next  = '0;
            taken_next = '0;
        end
        else if (busy_reg)
        begin
            if (pend_reg && adjacent)
            begin
                taken_next[rd_data.color] = 1'b1;
            end
            if (rd_en)
            begin
                pend_next = 1'b1;
                addr_next = addr_reg + gec_pkg::HELD_W'(1);
            end
            else if (!pend_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            done_reg <= done_next;
            addr_reg <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        taken_reg <= taken_next;
    end

endmodule

### src/greedy_edge_coloring.sv
// Greedy edge coloring: top level with the sequencer, edge store and result register.
// Depends on gec_pkg, gec_channels (interfaces), gec_ram and gec_scan.
//
// Usage: edge words arrive on the edges channel (vertex_a, vertex_b, last_edge).
// For each accepted word one result word leaves on the results channel: the
// smallest color free of adjacent earlier edges, the edge's position in its
// graph (1023 when the store is full), the colors used so far, a status code and the graph_done mark.
// Each accepted edge is scanned against every edge already stored in its graph
// (up to 1024), read once per stored edge through the single read port of the
// edge store, before its result goes to the result register. One edge is worked
// on at a time; edges.ready is high only while the sequencer is idle, which it
// becomes again together with the loading of the result register.
// A finished result waits in the output register while the next edge is taken
// and scanned; if the receiver still stalls when the next result is ready, the
// sequencer holds that result until the register frees.
// Reset clears the edge count, the color count and the output valid. The edge
// store needs no clearing pass: only entries written in the current graph are
// ever read. A last edge empties the store for the next graph.

module greedy_edge_coloring (
    input  logic                clk,
    input  logic                rst_n,
    gec_edge_if.sink            edges,
    gec_result_if.source        results
);

    gec_pkg::fsm_state_t                 state_reg, state_next;
    logic [gec_pkg::VERTEX_BITS-1:0]     a_reg, a_next;
    logic [gec_pkg::VERTEX_BITS-1:0]     b_reg, b_next;
    logic                                last_reg, last_next;
    logic [gec_pkg::HELD_W-1:0]          held_reg, held_next;
    logic [gec_pkg::USED_W-1:0]          count_reg, count_next;

    logic                                out_valid_reg, out_valid_next;
    logic [gec_pkg::COLOR_W-1:0]         out_color_reg, out_color_next;
    logic [gec_pkg::EDGE_AW-1:0]         out_number_reg, out_number_next;
    logic [gec_pkg::USED_W-1:0]          out_used_reg, out_used_next;
    gec_pkg::status_t                    out_status_reg, out_status_next;
    logic                                out_done_reg, out_done_next;

    logic                                scan_start;
    logic                                scan_done;
    logic [gec_pkg::MAX_COLORS-1:0]      taken;
    logic                                rd_en;
    logic [gec_pkg::EDGE_AW-1:0]         rd_addr;
    logic [gec_pkg::ENTRY_W-1:0]         rd_word;
    gec_pkg::edge_entry_t                rd_entry;
    logic                                wr_en;
    gec_pkg::edge_entry_t                wr_entry;

    gec_pkg::pick_t                      pick;
    logic                                store_full;
    logic                                out_free;
    logic [gec_pkg::USED_W-1:0]          color_plus_one;
    logic [gec_pkg::USED_W-1:0]          count_upd;

    assign rd_entry = gec_pkg::edge_entry_t'(rd_word);

    // Edge store.
    gec_ram #(
        .WIDTH (gec_pkg::ENTRY_W),
        .DEPTH (gec_pkg::MAX_EDGES)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (held_reg[gec_pkg::EDGE_AW-1:0]),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    // Adjacency scan over the stored edges.
    gec_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .held     (held_reg),
        .vertex_a (a_reg),
        .vertex_b (b_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_entry),
        .taken    (taken),
        .done     (scan_done)
    );

    // Color choice and count update.
    assign pick           = gec_pkg::first_free(taken);
    assign store_full     = (held_reg >= gec_pkg::HELD_W'(gec_pkg::MAX_EDGES));
    assign out_free       = !out_valid_reg || results.ready;
    assign color_plus_one = gec_pkg::USED_W'(pick.color) + gec_pkg::USED_W'(1);
    assign count_upd      = (color_plus_one > count_reg) ? color_plus_one : count_reg;

    assign wr_entry.first_end  = a_reg;
    assign wr_entry.second_end = b_reg;
    assign wr_entry.color      = pick.color;

    assign edges.ready         = (state_reg == gec_pkg::ST_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.edge_color  = out_color_reg;
    assign results.edge_number = out_number_reg;
    assign results.colors_used = out_used_reg;
    assign results.status      = out_status_reg;
    assign results.graph_done  = out_done_reg;

    // Sequencer: take an edge, scan the store, then pick, store and report.
    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        last_next       = last_reg;
        held_next       = held_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_color_next  = out_color_reg;
        out_number_next = out_number_reg;
        out_used_next   = out_used_reg;
        out_status_next = out_status_reg;
        out_done_next   = out_done_reg;
        scan_start      = 1'b0;
        wr_en           = 1'b0;
        case (state_reg)
            gec_pkg::ST_IDLE:
            begin
                if (edges.valid)
                begin
                    a_next     = edges.vertex_a[gec_pkg::VERTEX_BITS-1:0];
                    b_next     = edges.vertex_b[gec_pkg::VERTEX_BITS-1:0];
                    last_next  = edges.last_edge;
                    scan_start = 1'b1;
                    state_next = gec_pkg::ST_SCAN;
                end
            end
            gec_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = gec_pkg::ST_PICK;
                end
            end
            gec_pkg::ST_PICK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_color_next = pick.color;
                    out_used_next  = count_upd;
                    out_done_next  = last_reg;
                    if (store_full)
                    begin
                        out_status_next = gec_pkg::STATUS_STORE_FULL;
                        out_number_next = gec_pkg::EDGE_AW'(gec_pkg::MAX_EDGES - 1);
                    end
                    else
                    begin
                        out_status_next = pick.found ? gec_pkg::STATUS_OK
                                                     : gec_pkg::STATUS_COLOR_LIMIT;
                        out_number_next = held_reg[gec_pkg::EDGE_AW-1:0];
                        wr_en           = 1'b1;
                        held_next       = held_reg + gec_pkg::HELD_W'(1);
                    end
                    count_next = count_upd;
                    if (last_reg)
                    begin
                        held_next  = '0;
                        count_next = '0;
                    end
                    state_next = gec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gec_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gec_pkg::ST_IDLE;
            held_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        last_reg       <= last_next;
        out_color_reg  <= out_color_next;
        out_number_reg <= out_number_next;
        out_used_reg   <= out_used_next;
        out_status_reg <= out_status_next;
        out_done_reg   <= out_done_next;
    end

endmodule
